// File: rtl/core/uir_pkg.sv
// Shared types, constants and codes of the unique identifier registry.
package uir_pkg;

  localparam int TYPE_COUNT     = 8;
  localparam int SLOTS_PER_TYPE = 64;
  localparam int TOTAL_SLOTS    = TYPE_COUNT * SLOTS_PER_TYPE;

  localparam int IDENT_W = 32;
  localparam int ENTRY_W = IDENT_W + 1;
  localparam int ADDR_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int SLOT_W  = (SLOTS_PER_TYPE > 1) ? $clog2(SLOTS_PER_TYPE) : 1;
  localparam int SLOT_CW = $clog2(SLOTS_PER_TYPE + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TEST   = 2'd2;

  localparam logic signed [IDENT_W-1:0] NO_IDENT = -32'sd1;

  typedef struct packed {
    logic [1:0]                kind;
    logic [2:0]                id_type;
    logic signed [IDENT_W-1:0] ident;
  } req_t;

  typedef struct packed {
    logic accepted;
    logic store_full;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic clear_wr;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic clear_last;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/uir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/uir_ctrl.sv
// Control state machine of the unique identifier registry.
module uir_ctrl import uir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready    = (state == ST_IDLE);
  assign cmd.start    = req_ready && req_valid;
  assign cmd.clear_wr = (state == ST_CLEAR);
  assign cmd.scan     = (state == ST_SCAN);
  assign cmd.finish   = (state == ST_UPDATE) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = status.needs_scan ? ST_SCAN : ST_UPDATE;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_no_start_outside_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_SCAN) || (state == ST_UPDATE))
    else $error("transaction accepted without entering scan or update");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("update did not return to idle");

endmodule

// File: rtl/core/uir_dp.sv
// Datapath: slot memory, scan counters, update decision and result register.
module uir_dp import uir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp
);

  req_t               req_q;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  clr_addr;
  logic [SLOT_CW-1:0] issue_idx;
  logic               data_vld;
  logic [SLOT_W-1:0]  data_slot;
  logic               hit;
  logic [SLOT_W-1:0]  hit_slot;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic               in_range;
  logic               is_none;
  logic               upd_wr;
  logic [SLOT_W-1:0]  upd_slot;
  logic               upd_valid;
  rsp_t               res;
  logic               entry_match;

  assign in_range = int'(req_q.id_type) < TYPE_COUNT;
  assign is_none  = (req_q.ident == NO_IDENT);

  always_comb begin
    res.accepted   = 1'b0;
    res.store_full = 1'b0;
    upd_wr         = 1'b0;
    upd_slot       = free_slot;
    upd_valid      = 1'b0;
    if (in_range) begin
      unique case (req_q.kind)
        KIND_ADD: begin
          if (is_none) begin
            res.accepted = 1'b1;
          end else if (!hit) begin
            if (free_found) begin
              res.accepted = 1'b1;
              upd_wr       = 1'b1;
              upd_valid    = 1'b1;
            end else begin
              res.store_full = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          if (!is_none && hit) begin
            res.accepted = 1'b1;
            upd_wr       = 1'b1;
            upd_slot     = hit_slot;
          end
        end
        KIND_TEST: begin
          res.accepted = !hit;
        end
        default: begin
          res.accepted = 1'b0;
        end
      endcase
    end
  end

  assign rd_en   = cmd.scan && (issue_idx < SLOT_CW'(SLOTS_PER_TYPE));
  assign rd_addr = base + ADDR_W'(issue_idx[SLOT_W-1:0]);
  assign wr_en   = cmd.clear_wr || (cmd.finish && upd_wr);
  assign wr_addr = cmd.clear_wr ? clr_addr : base + ADDR_W'(upd_slot);
  assign wr_data = cmd.clear_wr ? '0 : {upd_valid, req_q.ident};

  uir_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TOTAL_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign entry_match = rd_data[ENTRY_W-1] && (rd_data[IDENT_W-1:0] == $unsigned(req_q.ident));

  assign status.needs_scan = (int'(req.id_type) < TYPE_COUNT)
                             && (req.kind == KIND_ADD || req.kind == KIND_REMOVE
                                 || req.kind == KIND_TEST)
                             && (req.ident != NO_IDENT);
  assign status.clear_last = (clr_addr == ADDR_W'(TOTAL_SLOTS - 1));
  assign status.scan_done  = hit
                             || ((issue_idx == SLOT_CW'(SLOTS_PER_TYPE)) && !data_vld);
  assign status.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr && !status.clear_last) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q      <= req;
      base       <= ADDR_W'(req.id_type) * ADDR_W'(SLOTS_PER_TYPE);
      issue_idx  <= '0;
      data_vld   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      data_vld <= rd_en;
      if (rd_en) begin
        issue_idx <= issue_idx + SLOT_CW'(1);
        data_slot <= issue_idx[SLOT_W-1:0];
      end
      if (data_vld) begin
        if (entry_match && !hit) begin
          hit      <= 1'b1;
          hit_slot <= data_slot;
        end
        if (!rd_data[ENTRY_W-1] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= data_slot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp <= res;
    end
  end

  a_finish_loads_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp_valid)
    else $error("finished transaction left no result");

  a_start_clears_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !hit && !free_found && !data_vld)
    else $error("scan state not cleared at start");

  a_full_means_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.store_full |-> !rsp.accepted)
    else $error("store full reported on an accepted request");

endmodule

// File: rtl/core/unique_id_registry.sv
// Top level of the unique identifier registry.
// Keeps one set of 32-bit identifiers per identifier type in a slot memory
// with SLOTS_PER_TYPE slots per type. After reset the block sweeps the whole
// slot memory once, one slot a cycle, with req_ready low. A request that
// needs no lookup (type out of range, unknown kind, or the no-identifier
// value -1) goes straight to the update without a scan. Any other request
// scans the slots of its type through the single read port, one slot a
// cycle, stopping at a match. One request is worked on at a time; a new one
// is taken while the previous result still waits in the output register.
module unique_id_registry import uir_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  uir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .status   (status),
    .cmd      (cmd)
  );

  uir_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .status   (status),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule
